// File: sv/assert_macros.svh
// Shared assertion forms: overlapping and next-cycle implication, both
// disabled while the synchronous active-low reset is applied.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: sv/cdpwm_pkg.sv
`default_nettype none

package cdpwm_pkg;

    localparam int DUTY_W = 13;
    localparam int STEP_W = 8;
    localparam int ADV_W  = DUTY_W + 1;
    localparam int BIT_CNT_W = 4;

    localparam logic [DUTY_W-1:0] DUTY_MAX  = 13'd8191;
    localparam logic [DUTY_W-1:0] DUTY_STEP = 13'd10;

    localparam logic [DUTY_W-1:0] RST_STEER_HIGH    = 13'd665;
    localparam logic [DUTY_W-1:0] RST_STEER_LOW     = 13'd330;
    localparam logic [DUTY_W-1:0] RST_SPEED_HIGH    = 13'd610;
    localparam logic [DUTY_W-1:0] RST_SPEED_LOW     = 13'd310;
    localparam logic [DUTY_W-1:0] RST_STEER_NEUTRAL = 13'd480;
    localparam logic [DUTY_W-1:0] RST_SPEED_NEUTRAL = 13'd460;
    localparam logic [DUTY_W-1:0] RST_PWM_PERIOD    = 13'd5000;
    localparam logic [STEP_W-1:0] RST_TICK_STEP     = 8'd10;

    // Command characters
    localparam logic [7:0] CH_STEER_UP   = 8'h64; // 'd'
    localparam logic [7:0] CH_STEER_DOWN = 8'h62; // 'b'
    localparam logic [7:0] CH_SPEED_UP   = 8'h61; // 'a'
    localparam logic [7:0] CH_SPEED_DOWN = 8'h63; // 'c'
    localparam logic [7:0] CH_ENABLE     = 8'h65; // 'e'
    localparam logic [7:0] CH_DISABLE    = 8'h66; // 'f'

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef enum logic [2:0] {
        CFG_STEER_HIGH    = 3'd0,
        CFG_STEER_LOW     = 3'd1,
        CFG_SPEED_HIGH    = 3'd2,
        CFG_SPEED_LOW     = 3'd3,
        CFG_STEER_NEUTRAL = 3'd4,
        CFG_SPEED_NEUTRAL = 3'd5,
        CFG_PWM_PERIOD    = 3'd6,
        CFG_TICK_STEP     = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } t_in;

    typedef struct packed {
        logic              steer_pin;
        logic              speed_pin;
        logic              red_led_on;
        logic              green_led_on;
        logic              blue_led_on;
        logic [DUTY_W-1:0] steer_duty_now;
        logic [DUTY_W-1:0] speed_duty_now;
    } t_out;

    typedef struct packed {
        logic              start;
        logic [ADV_W-1:0]  dividend;
        logic [DUTY_W-1:0] divisor;
    } t_mod_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DUTY_W-1:0] rem;
    } t_mod_rsp;

endpackage

`default_nettype wire

// File: sv/command_driven_dual_pwm_unit.sv
// Channel   Direction  Handshake                  Word
// in        input      i_in_valid / o_in_ready    t_in  (req_type, rx_byte)
// out       output     o_out_valid / i_out_ready  t_out (pins, LEDs, duties)
// cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One word per cycle unless stalled: a word waits in the input register, is
// decoded against the duty, LED, pin and counter state, and lands in the output
// register. A tick whose advanced count reaches twice a nonzero period (or more)
// finishes the counter wrap in the bit-serial remainder unit: its result leaves
// at once, but the next word waits for that unit. Reset (synchronous, active low)
// restores the register defaults and clears all state but the enable, which it
// sets; no clearing pass. A full output register with i_out_ready low stalls the
// input register, which then drops o_in_ready. o_cfg_ready is always high.
`default_nettype none

`include "assert_macros.svh"

module command_driven_dual_pwm_unit
    import cdpwm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,

    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire t_in               i_in_data,

    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_out                   o_out_data,

    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [2:0]        i_cfg_index,
    input  wire logic [DUTY_W-1:0] i_cfg_data
);

    // Step a duty up when at or below the limit, else load the limit; clip at max.
    function automatic logic [DUTY_W-1:0] duty_up(
        input logic [DUTY_W-1:0] d,
        input logic [DUTY_W-1:0] lim
    );
        logic [ADV_W-1:0] s;
        s = {1'b0, d} + {1'b0, DUTY_STEP};
        if (d <= lim) begin
            return (s > {1'b0, DUTY_MAX}) ? DUTY_MAX : s[DUTY_W-1:0];
        end
        return lim;
    endfunction

    // Step a duty down at or above the limit, else load the limit; floor at zero.
    function automatic logic [DUTY_W-1:0] duty_down(
        input logic [DUTY_W-1:0] d,
        input logic [DUTY_W-1:0] lim
    );
        if (d >= lim) begin
            return (d >= DUTY_STEP) ? (d - DUTY_STEP) : '0;
        end
        return lim;
    endfunction

    // Configuration registers
    logic [DUTY_W-1:0] r_steer_high;
    logic [DUTY_W-1:0] r_steer_low;
    logic [DUTY_W-1:0] r_speed_high;
    logic [DUTY_W-1:0] r_speed_low;
    logic [DUTY_W-1:0] r_steer_neutral;
    logic [DUTY_W-1:0] r_speed_neutral;
    logic [DUTY_W-1:0] r_pwm_period;
    logic [STEP_W-1:0] r_tick_step;

    // Block state
    logic [DUTY_W-1:0] r_steer_duty, n_steer_duty;
    logic [DUTY_W-1:0] r_speed_duty, n_speed_duty;
    logic [DUTY_W-1:0] r_pwm_count,  n_pwm_count;
    logic              r_enabled,    n_enabled;
    logic [2:0]        r_led,        n_led;       // {blue, green, red}
    logic [1:0]        r_pins,       n_pins;      // {speed, steer}

    // Pipeline registers
    logic              r_in_valid;
    t_in               r_in;
    logic              r_out_valid;
    t_out              r_out;

    logic              w_out_free;
    logic              w_move;
    logic [ADV_W-1:0]  w_adv;
    logic [ADV_W-1:0]  w_twice_period;
    logic [ADV_W-1:0]  w_adv_less_period;
    t_mod_req          w_mod_req;
    t_mod_rsp          w_mod_rsp;

    cdpwm_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mod_req),
        .o_rsp   (w_mod_rsp)
    );

    // Advance the stage when the output slot frees up and no wrap is running.
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_move      = r_in_valid && w_out_free && !w_mod_rsp.busy;
    assign o_in_ready  = !r_in_valid || w_move;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_adv             = {1'b0, r_pwm_count} + {{(ADV_W-STEP_W){1'b0}}, r_tick_step};
    assign w_twice_period    = {r_pwm_period, 1'b0};
    assign w_adv_less_period = w_adv - {1'b0, r_pwm_period};

    always_comb begin
        n_steer_duty       = r_steer_duty;
        n_speed_duty       = r_speed_duty;
        n_pwm_count        = r_pwm_count;
        n_enabled          = r_enabled;
        n_led              = r_led;
        n_pins             = r_pins;
        w_mod_req.start    = 1'b0;
        w_mod_req.dividend = w_adv;
        w_mod_req.divisor  = r_pwm_period;

        if (w_move) begin
            if (r_in.req_type == REQ_TICK) begin
                // Compare the advanced count before the wrap.
                n_pins = {w_adv < {1'b0, r_speed_duty}, w_adv < {1'b0, r_steer_duty}};
                priority if (r_pwm_period == '0) begin
                    n_pwm_count = w_adv[DUTY_W-1:0];
                end else if (w_adv < {1'b0, r_pwm_period}) begin
                    n_pwm_count = w_adv[DUTY_W-1:0];
                end else if (w_adv < w_twice_period) begin
                    n_pwm_count = w_adv_less_period[DUTY_W-1:0];
                end else begin
                    // Hand the full remainder to the serial unit.
                    w_mod_req.start = 1'b1;
                end
            end else begin
                if (r_enabled) begin
                    unique case (r_in.rx_byte)
                        CH_STEER_UP: begin
                            n_steer_duty = duty_up(r_steer_duty, r_steer_high);
                            n_led[0]     = 1'b1;
                        end
                        CH_STEER_DOWN: begin
                            n_steer_duty = duty_down(r_steer_duty, r_steer_low);
                            n_led[1]     = 1'b1;
                        end
                        CH_SPEED_UP: begin
                            n_speed_duty = duty_up(r_speed_duty, r_speed_high);
                            n_led[0]     = 1'b1;
                        end
                        CH_SPEED_DOWN: begin
                            n_speed_duty = duty_down(r_speed_duty, r_speed_low);
                            n_led[1]     = 1'b1;
                        end
                        default: begin
                            // Unknown byte, enable and disable included: go neutral.
                            n_steer_duty = r_steer_neutral;
                            n_speed_duty = r_speed_neutral;
                            n_led        = 3'b100;
                        end
                    endcase
                end
                if (r_in.rx_byte == CH_DISABLE) begin
                    n_enabled = 1'b0;
                end
                if (r_in.rx_byte == CH_ENABLE) begin
                    n_enabled = 1'b1;
                end
            end
        end

        if (w_mod_rsp.done) begin
            n_pwm_count = w_mod_rsp.rem;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steer_high    <= RST_STEER_HIGH;
            r_steer_low     <= RST_STEER_LOW;
            r_speed_high    <= RST_SPEED_HIGH;
            r_speed_low     <= RST_SPEED_LOW;
            r_steer_neutral <= RST_STEER_NEUTRAL;
            r_speed_neutral <= RST_SPEED_NEUTRAL;
            r_pwm_period    <= RST_PWM_PERIOD;
            r_tick_step     <= RST_TICK_STEP;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_STEER_HIGH:    r_steer_high    <= i_cfg_data;
                CFG_STEER_LOW:     r_steer_low     <= i_cfg_data;
                CFG_SPEED_HIGH:    r_speed_high    <= i_cfg_data;
                CFG_SPEED_LOW:     r_speed_low     <= i_cfg_data;
                CFG_STEER_NEUTRAL: r_steer_neutral <= i_cfg_data;
                CFG_SPEED_NEUTRAL: r_speed_neutral <= i_cfg_data;
                CFG_PWM_PERIOD:    r_pwm_period    <= i_cfg_data;
                CFG_TICK_STEP:     r_tick_step     <= i_cfg_data[STEP_W-1:0];
                default:           r_tick_step     <= r_tick_step;
            endcase
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steer_duty <= '0;
            r_speed_duty <= '0;
            r_pwm_count  <= '0;
            r_enabled    <= 1'b1;
            r_led        <= '0;
            r_pins       <= '0;
        end else begin
            r_steer_duty <= n_steer_duty;
            r_speed_duty <= n_speed_duty;
            r_pwm_count  <= n_pwm_count;
            r_enabled    <= n_enabled;
            r_led        <= n_led;
            r_pins       <= n_pins;
        end
    end

    // Input register: hold a word until the decode stage takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    // Output register: hold the result until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out.steer_pin      <= n_pins[0];
            r_out.speed_pin      <= n_pins[1];
            r_out.red_led_on     <= n_led[0];
            r_out.green_led_on   <= n_led[1];
            r_out.blue_led_on    <= n_led[2];
            r_out.steer_duty_now <= n_steer_duty;
            r_out.speed_duty_now <= n_speed_duty;
        end
    end

    // A byte seen while disabled leaves both duties alone.
    `ASSERT_NEXT(a_disabled_keeps_duty, i_clk, i_rst_n,
        w_move && (r_in.req_type == REQ_BYTE) && !r_enabled,
        $stable(r_steer_duty) && $stable(r_speed_duty))
    // A tick never touches the duties or the LEDs.
    `ASSERT_NEXT(a_tick_keeps_duty, i_clk, i_rst_n,
        w_move && (r_in.req_type == REQ_TICK),
        $stable(r_steer_duty) && $stable(r_speed_duty) && $stable(r_led))
    // Hold a result word steady until the sink takes it.
    `ASSERT_NEXT(a_out_held, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_out_data))

endmodule

`default_nettype wire

// File: sv/cdpwm_mod.sv
`default_nettype none

`include "assert_macros.svh"

// Restoring remainder unit: one dividend bit per cycle, MSB first.
module cdpwm_mod
    import cdpwm_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_mod_req i_req,
    output t_mod_rsp      o_rsp
);

    logic                 r_busy;
    logic [BIT_CNT_W-1:0] r_cnt;
    logic [DUTY_W-1:0]    r_rem;
    logic [ADV_W-1:0]     r_num;
    logic [DUTY_W-1:0]    r_div;

    logic [ADV_W-1:0] w_trial;
    logic             w_fits;
    logic [ADV_W-1:0] w_next;

    assign w_trial = {r_rem, r_num[ADV_W-1]};
    assign w_fits  = w_trial >= {1'b0, r_div};
    assign w_next  = w_fits ? (w_trial - {1'b0, r_div}) : w_trial;

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_busy && (r_cnt == '0);
    assign o_rsp.rem  = w_next[DUTY_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= BIT_CNT_W'(ADV_W - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Latch the divisor so a later period write cannot disturb a running pass.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_num <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_next[DUTY_W-1:0];
            r_num <= {r_num[ADV_W-2:0], 1'b0};
        end
    end

    `ASSERT_IMPLY(a_start_when_idle, i_clk, i_rst_n, i_req.start, !r_busy)
    `ASSERT_IMPLY(a_rem_below_div, i_clk, i_rst_n, r_busy, r_rem < r_div)
    `ASSERT_NEXT(a_idle_after_done, i_clk, i_rst_n, o_rsp.done, !r_busy)

endmodule

`default_nettype wire

// File: tb/sv/command_driven_dual_pwm_unit_tb.sv
`default_nettype none

module command_driven_dual_pwm_unit_tb
    import cdpwm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles with no accepted word on any channel before the run is declared hung.
    // The slowest legal word waits out a remainder pass, plus the longest receiver stall and
    // sender gap used below, so this is many times the worst honest pause.
    localparam int WATCHDOG_LIMIT = 2000;
    // Quiet time after the last status word: covers the remainder drain.
    localparam int SETTLE_CYCLES  = 20;
    localparam int MAX_REPORTS    = 10;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic              in_valid  = 1'b0;
    logic              in_ready;
    t_in               in_word   = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    t_out              out_word;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [2:0]        cfg_index = '0;
    logic [DUTY_W-1:0] cfg_data  = '0;

    // Words waiting to be offered, and status words owed by the block.
    t_in  cmd_stream[$];
    t_out status_due[$];

    // Register copies, at their reset values.
    logic [DUTY_W-1:0] steer_ceiling = RST_STEER_HIGH;
    logic [DUTY_W-1:0] steer_floor   = RST_STEER_LOW;
    logic [DUTY_W-1:0] speed_ceiling = RST_SPEED_HIGH;
    logic [DUTY_W-1:0] speed_floor   = RST_SPEED_LOW;
    logic [DUTY_W-1:0] steer_center  = RST_STEER_NEUTRAL;
    logic [DUTY_W-1:0] speed_center  = RST_SPEED_NEUTRAL;
    logic [DUTY_W-1:0] pwm_period    = RST_PWM_PERIOD;
    logic [STEP_W-1:0] tick_step     = RST_TICK_STEP;

    // Predicted PWM/LED state, cleared as after reset.
    logic [DUTY_W-1:0] steer_duty_m = '0;
    logic [DUTY_W-1:0] speed_duty_m = '0;
    logic [DUTY_W-1:0] pwm_count_m  = '0;
    logic              cmds_enabled = 1'b1;
    logic              red_lit      = 1'b0;
    logic              green_lit    = 1'b0;
    logic              blue_lit     = 1'b0;
    logic              steer_lvl    = 1'b0;
    logic              speed_lvl    = 1'b0;

    // Idling controls, set per phase while the block is quiet.
    int tx_gap_max   = 0;
    int rx_stall_max = 0;
    int burst_left   = 0;
    int idle_left    = 0;
    int hold_left    = 0;

    int stall_cycles = 0;
    bit timed_out    = 1'b0;
    int mismatches   = 0;
    int checked      = 0;
    int ticks_sent   = 0;
    int bytes_sent   = 0;
    int cfg_writes   = 0;
    int settings     = 1;

    command_driven_dual_pwm_unit dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_word),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_word),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Duty arithmetic
    // ------------------------------------------------------------------

    // Step up while at or below the ceiling, else snap to it; clip at full scale.
    function automatic logic [DUTY_W-1:0] duty_raised(input logic [DUTY_W-1:0] d,
                                                      input logic [DUTY_W-1:0] ceiling);
        logic [DUTY_W:0] sum;
        sum = {1'b0, d} + {1'b0, DUTY_STEP};
        if (d > ceiling) return ceiling;
        return (sum > {1'b0, DUTY_MAX}) ? DUTY_MAX : sum[DUTY_W-1:0];
    endfunction

    // Step down while at or above the floor, else snap to it; clip at zero.
    function automatic logic [DUTY_W-1:0] duty_lowered(input logic [DUTY_W-1:0] d,
                                                       input logic [DUTY_W-1:0] floor_v);
        if (d < floor_v) return floor_v;
        return (d >= DUTY_STEP) ? d - DUTY_STEP : '0;
    endfunction

    // Advance the predicted state by one accepted word and queue the status it owes.
    task automatic predict_status(input t_in w);
        logic [ADV_W-1:0] adv;
        t_out             s;
        if (w.req_type == REQ_TICK) begin
            // Compare the advanced count before the wrap: it can exceed any duty.
            adv       = {1'b0, pwm_count_m} + {{(ADV_W-STEP_W){1'b0}}, tick_step};
            steer_lvl = adv < {1'b0, steer_duty_m};
            speed_lvl = adv < {1'b0, speed_duty_m};
            // A zero period leaves only the counter's own 13-bit wrap.
            if (pwm_period != '0) adv = adv % {1'b0, pwm_period};
            pwm_count_m = adv[DUTY_W-1:0];
            ticks_sent++;
        end else begin
            if (cmds_enabled) begin
                case (w.rx_byte)
                    CH_STEER_UP: begin
                        steer_duty_m = duty_raised(steer_duty_m, steer_ceiling);
                        red_lit      = 1'b1;
                    end
                    CH_STEER_DOWN: begin
                        steer_duty_m = duty_lowered(steer_duty_m, steer_floor);
                        green_lit    = 1'b1;
                    end
                    CH_SPEED_UP: begin
                        speed_duty_m = duty_raised(speed_duty_m, speed_ceiling);
                        red_lit      = 1'b1;
                    end
                    CH_SPEED_DOWN: begin
                        speed_duty_m = duty_lowered(speed_duty_m, speed_floor);
                        green_lit    = 1'b1;
                    end
                    default: begin
                        // Anything else, enable/disable included, recenters and shows blue only.
                        steer_duty_m = steer_center;
                        speed_duty_m = speed_center;
                        red_lit      = 1'b0;
                        green_lit    = 1'b0;
                        blue_lit     = 1'b1;
                    end
                endcase
            end
            if (w.rx_byte == CH_DISABLE) cmds_enabled = 1'b0;
            if (w.rx_byte == CH_ENABLE)  cmds_enabled = 1'b1;
            bytes_sent++;
        end
        s.steer_pin      = steer_lvl;
        s.speed_pin      = speed_lvl;
        s.red_led_on     = red_lit;
        s.green_led_on   = green_lit;
        s.blue_led_on    = blue_lit;
        s.steer_duty_now = steer_duty_m;
        s.speed_duty_now = speed_duty_m;
        status_due.push_back(s);
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task automatic check_field(input string name, input logic [DUTY_W-1:0] want_v,
                               input logic [DUTY_W-1:0] got_v);
        if (got_v !== want_v)
            note_mismatch($sformatf("status word %0d, %s: expected %0d, got %0d",
                                    checked, name, want_v, got_v));
    endtask

    task automatic check_status(input t_out got);
        t_out want;
        if (status_due.size() == 0) begin
            note_mismatch($sformatf("status word %0d arrived with nothing due (0x%h)",
                                    checked, got));
        end else begin
            want = status_due.pop_front();
            check_field("steer_pin", DUTY_W'(want.steer_pin), DUTY_W'(got.steer_pin));
            check_field("speed_pin", DUTY_W'(want.speed_pin), DUTY_W'(got.speed_pin));
            check_field("red_led_on", DUTY_W'(want.red_led_on), DUTY_W'(got.red_led_on));
            check_field("green_led_on", DUTY_W'(want.green_led_on),
                        DUTY_W'(got.green_led_on));
            check_field("blue_led_on", DUTY_W'(want.blue_led_on), DUTY_W'(got.blue_led_on));
            check_field("steer_duty_now", want.steer_duty_now, got.steer_duty_now);
            check_field("speed_duty_now", want.speed_duty_now, got.speed_duty_now);
        end
        checked++;
    endtask

    // ------------------------------------------------------------------
    // Driver: offer queued words in bursts, predict each one as it is taken
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) predict_status(in_word);
            // Only touch the channel when no word is held or the held one just went.
            if (!in_valid || in_ready) begin
                if (idle_left != 0) begin
                    idle_left = idle_left - 1;
                    in_valid <= 1'b0;
                end else if (cmd_stream.size() != 0) begin
                    in_word  <= cmd_stream.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left != 0) begin
                        burst_left = burst_left - 1;
                    end else begin
                        // End of burst: pick the next burst length and the gap before it.
                        burst_left = $urandom_range(0, 31);
                        idle_left  = (tx_gap_max == 0) ? 0 : $urandom_range(1, tx_gap_max);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each taken status word, stall the output on its own pattern
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) check_status(out_word);
            if (hold_left != 0) begin
                hold_left = hold_left - 1;
            end else if (out_ready && rx_stall_max != 0) begin
                out_ready <= 1'b0;
                hold_left = $urandom_range(0, rx_stall_max - 1);
            end else begin
                out_ready <= 1'b1;
                hold_left = $urandom_range(0, 23);
            end
        end
    end

    // Count cycles in which no channel moves a word.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic push_byte(input logic [7:0] b);
        t_in w;
        w.req_type = REQ_BYTE;
        w.rx_byte  = b;
        cmd_stream.push_back(w);
    endtask

    // The byte field is junk on a tick; fill it at random, command characters included.
    task automatic push_tick();
        t_in w;
        w.req_type = REQ_TICK;
        w.rx_byte  = 8'($urandom_range(0, 255));
        cmd_stream.push_back(w);
    endtask

    // Hold until every word is sent and answered, then let the remainder unit finish.
    task automatic wait_idle();
        while (cmd_stream.size() != 0 || in_valid || status_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [DUTY_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_STEER_HIGH:    steer_ceiling = val;
            CFG_STEER_LOW:     steer_floor   = val;
            CFG_SPEED_HIGH:    speed_ceiling = val;
            CFG_SPEED_LOW:     speed_floor   = val;
            CFG_STEER_NEUTRAL: steer_center  = val;
            CFG_SPEED_NEUTRAL: speed_center  = val;
            CFG_PWM_PERIOD:    pwm_period    = val;
            CFG_TICK_STEP:     tick_step     = val[STEP_W-1:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic load_setting(input logic [DUTY_W-1:0] sh, sl, ph, pl, sn, pn, per, stp);
        write_reg(CFG_STEER_HIGH,    sh);
        write_reg(CFG_STEER_LOW,     sl);
        write_reg(CFG_SPEED_HIGH,    ph);
        write_reg(CFG_SPEED_LOW,     pl);
        write_reg(CFG_STEER_NEUTRAL, sn);
        write_reg(CFG_SPEED_NEUTRAL, pn);
        write_reg(CFG_PWM_PERIOD,    per);
        write_reg(CFG_TICK_STEP,     stp);
        settings++;
    endtask

    // Limits and centers mostly near each other so duties hit both sides of
    // every limit; periods often tiny so ticks take the slow remainder path.
    task automatic load_random_setting();
        logic [DUTY_W-1:0] v[6];
        logic [DUTY_W-1:0] per;
        logic [DUTY_W-1:0] stp;
        foreach (v[i])
            v[i] = ($urandom_range(0, 3) == 0) ? DUTY_W'($urandom_range(0, 8191))
                                                : DUTY_W'($urandom_range(0, 900));
        case ($urandom_range(0, 9))
            0:       per = '0;
            1, 2:    per = DUTY_W'($urandom_range(1, 16));
            default: per = DUTY_W'($urandom_range(17, 8191));
        endcase
        // Upper data bits are dropped by the step register; drive them anyway.
        stp = DUTY_W'($urandom_range(0, 8191));
        if ($urandom_range(0, 9) == 0) stp[STEP_W-1:0] = '0;
        load_setting(v[0], v[1], v[2], v[3], v[4], v[5], per, stp);
    endtask

    // Mostly runs of one duty command mixed with ticks, some recentering bytes,
    // and disable/enable brackets with ignored bytes inside.
    task automatic queue_random_words(input int n);
        int         queued;
        int         pick;
        int         run;
        logic [7:0] op;
        queued = 0;
        while (queued < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                push_tick();
                queued++;
            end else if (pick < 82) begin
                case ($urandom_range(0, 3))
                    0:       op = CH_STEER_UP;
                    1:       op = CH_STEER_DOWN;
                    2:       op = CH_SPEED_UP;
                    default: op = CH_SPEED_DOWN;
                endcase
                run = $urandom_range(1, 24);
                repeat (run) begin
                    if ($urandom_range(0, 3) == 0) push_tick();
                    else push_byte(op);
                end
                queued += run;
            end else if (pick < 91) begin
                push_byte(8'($urandom_range(0, 255)));
                queued++;
            end else begin
                push_byte(CH_DISABLE);
                repeat ($urandom_range(0, 4)) push_byte(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 7) != 0) push_byte(CH_ENABLE);
                queued += 2;
            end
        end
    endtask

    task automatic run_phase(input int n, input int gap, input int stall);
        tx_gap_max   = gap;
        rx_stall_max = stall;
        queue_random_words(n);
        wait_idle();
    endtask

    task automatic run_stimulus();
        // Directed pass on reset registers, duties starting at zero.
        push_tick();              // tick ignores its byte, pins stay low on zero duty
        push_byte(CH_STEER_UP);   // increase below ceiling
        push_byte(CH_SPEED_UP);
        push_byte(CH_STEER_DOWN); // decrease under the floor snaps to it
        push_byte(CH_SPEED_DOWN);
        push_byte(CH_STEER_DOWN); // decrease at the floor steps down
        push_tick();              // both pins high now
        push_byte(8'h00);         // unrecognized bytes at both extremes
        push_byte(8'hFF);
        push_byte(CH_ENABLE);     // enable while enabled recenters like any other byte
        push_byte(CH_DISABLE);    // recenters, then disables
        push_byte(CH_STEER_UP);   // ignored while disabled
        push_byte(CH_DISABLE);    // ignored too
        push_tick();              // ticks still run while disabled
        push_byte(CH_ENABLE);     // re-enables and nothing else
        push_byte(CH_STEER_UP);   // red joins blue
        push_byte(CH_SPEED_DOWN); // green joins too
        tx_gap_max   = 2;
        rx_stall_max = 3;
        wait_idle();

        // Reset registers, no idling on either side.
        run_phase(230, 0, 0);

        // Everything at full scale: duties saturate, the count runs past 8191.
        load_setting(DUTY_MAX, DUTY_MAX, DUTY_MAX, DUTY_MAX, DUTY_MAX, DUTY_MAX,
                     DUTY_MAX, DUTY_MAX);
        run_phase(230, 6, 8);

        // Everything zero: zero step, zero period, decreases clip at zero.
        load_setting('0, '0, '0, '0, '0, '0, '0, 13'h1F00);
        run_phase(150, 3, 3);

        // Tiny period, so most ticks need the multi-cycle wrap.
        load_setting(13'd200, 13'd100, 13'd150, 13'd40, 13'd5, 13'd3,
                     DUTY_W'($urandom_range(1, 12)), DUTY_W'($urandom_range(0, 8191)));
        run_phase(230, 10, 12);

        repeat (4) begin
            load_random_setting();
            run_phase(250, $urandom_range(0, 10), $urandom_range(0, 12));
        end
    endtask

    // ------------------------------------------------------------------
    // Run control
    // ------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        fork
            run_stimulus();
            begin
                wait (stall_cycles >= WATCHDOG_LIMIT);
                timed_out = 1'b1;
            end
        join_any
        $display("Sent %0d words (%0d ticks, %0d command bytes) under %0d register settings",
                 ticks_sent + bytes_sent, ticks_sent, bytes_sent, settings);
        $display("Checked %0d status words after %0d register writes: %0d mismatches",
                 checked, cfg_writes, mismatches);
        if (timed_out)
            $display("No word moved for %0d cycles, run abandoned", WATCHDOG_LIMIT);
        if (!timed_out && mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+sv
sv/cdpwm_pkg.sv
sv/cdpwm_mod.sv
sv/command_driven_dual_pwm_unit.sv
tb/sv/command_driven_dual_pwm_unit_tb.sv
